// ===== sv/ffwq_pkg.sv =====
package ffwq_pkg;

    localparam int KEY_W  = 64;
    localparam int SIZE_W = 8;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SHOW   = 2'd2,
        ACT_LIST   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_DONE   = 3'd0,
        ST_LISTED = 3'd1,
        ST_FULL   = 3'd2,
        ST_DUP    = 3'd3,
        ST_NOFIT  = 3'd4,
        ST_EMPTY  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

    typedef struct packed {
        t_action             action;
        logic [KEY_W-1:0]    entry_key;
        logic [SIZE_W-1:0]   entry_size;
        logic [SIZE_W-1:0]   size_limit;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [KEY_W-1:0]    out_key;
        logic [SIZE_W-1:0]   out_size;
        logic                last;
    } t_out_item;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [SIZE_W-1:0]   size;
    } t_entry;

    typedef struct packed {
        logic key_eq;
        logic take;
    } t_match;

endpackage

// ===== sv/ffwq_ram.sv =====
module ffwq_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ffwq_match.sv =====
module ffwq_match (
    input  ffwq_pkg::t_in_item i_cmd,
    input  ffwq_pkg::t_entry   i_entry,
    output ffwq_pkg::t_match   o_match
);
    import ffwq_pkg::*;

    always_comb begin
        o_match.key_eq = (i_entry.key == i_cmd.entry_key);
        o_match.take   = (i_cmd.action == ACT_LIST) || (i_entry.size <= i_cmd.size_limit);
    end

endmodule

// ===== sv/first_fit_wait_queue_top.sv =====
// First-fit wait queue of keyed entries (64-bit key, 8-bit size).
// Command channel: i_cmd is taken at a rising edge with start high and busy
// low. busy stays high until the command's final result has been issued.
// Result channel: each result sits on o_result for one cycle with o_strobe
// high; the receiver cannot stall it, so it must take every strobe.
// o_result.last marks the final result of a command.
// Insert: scans the n valid entries for a duplicate key, one entry a cycle
// through the entry RAM read port, then appends. A full queue answers in
// the cycle after the transfer without going busy.
// Remove: scans to the oldest fitting entry at position p, then closes the
// gap one entry a cycle.
// Show and list: one scan of n entries, one result per emitted entry; each
// entry is held back in a register so that the final one can carry last.
// The entry RAM port, one read and one write a cycle, paces these scans.
// A synchronous reset empties the queue; RAM contents are left as they are.
module first_fit_wait_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ffwq_pkg::t_in_item  i_cmd,
    output logic                o_strobe,
    output ffwq_pkg::t_out_item o_result
);
    import ffwq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = KEY_W + SIZE_W;

    t_state           r_state, n_state;
    t_in_item         r_cmd, n_cmd;
    logic [CW-1:0]    r_occ, n_occ;
    logic [CW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_dv, n_dv;
    logic [AW-1:0]    r_dv_idx, n_dv_idx;
    t_entry           r_pend, n_pend;
    logic             r_pend_v, n_pend_v;
    t_out_item        r_out, n_out;
    logic             r_strobe, n_strobe;

    logic             we;
    logic [AW-1:0]    waddr;
    t_entry           wdata;
    t_entry           rdata;
    t_match           hit;
    logic             rd_more;
    logic             sweep_done;
    logic             full;

    function automatic t_out_item mk_out(t_status st, t_entry e, logic lst);
        t_out_item o;
        o.status   = st;
        o.out_key  = e.key;
        o.out_size = e.size;
        o.last     = lst;
        return o;
    endfunction

    ffwq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    ffwq_match u_match (
        .i_cmd   (r_cmd),
        .i_entry (rdata),
        .o_match (hit)
    );

    assign rd_more    = (r_rd_idx < r_occ);
    assign sweep_done = !rd_more && !r_dv;
    assign full       = (r_occ == CW'(QUEUE_DEPTH));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start && !(i_cmd.action == ACT_INSERT && full)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_dv) begin
                    if (r_cmd.action == ACT_INSERT && hit.key_eq) begin
                        n_state = S_IDLE;
                    end else if (r_cmd.action == ACT_REMOVE && hit.take) begin
                        n_state = S_SHIFT;
                    end
                end else if (sweep_done) begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                if (sweep_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd    = r_cmd;
        n_occ    = r_occ;
        n_rd_idx = r_rd_idx;
        n_dv     = 1'b0;
        n_dv_idx = r_dv_idx;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_out    = '0;
        n_strobe = 1'b0;
        we       = 1'b0;
        waddr    = r_dv_idx - AW'(1);
        wdata    = rdata;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd    = i_cmd;
                    n_rd_idx = '0;
                    n_pend_v = 1'b0;
                    if (i_cmd.action == ACT_INSERT && full) begin
                        n_strobe = 1'b1;
                        n_out    = mk_out(ST_FULL, '0, 1'b1);
                    end
                end
            end
            S_SCAN: begin
                if (rd_more) begin
                    n_rd_idx = r_rd_idx + CW'(1);
                    n_dv     = 1'b1;
                    n_dv_idx = r_rd_idx[AW-1:0];
                end
                if (r_dv) begin
                    unique case (r_cmd.action) inside
                        ACT_INSERT: begin
                            if (hit.key_eq) begin
                                n_strobe = 1'b1;
                                n_out    = mk_out(ST_DUP, '0, 1'b1);
                            end
                        end
                        ACT_REMOVE: begin
                            if (hit.take) begin
                                n_rd_idx = CW'(r_dv_idx) + CW'(1);
                                n_dv     = 1'b0;
                            end
                        end
                        ACT_SHOW, ACT_LIST: begin
                            if (hit.take) begin
                                if (r_pend_v) begin
                                    n_strobe = 1'b1;
                                    n_out    = mk_out(ST_LISTED, r_pend, 1'b0);
                                end
                                n_pend   = rdata;
                                n_pend_v = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end else if (sweep_done) begin
                    n_strobe = 1'b1;
                    unique case (r_cmd.action) inside
                        ACT_INSERT: begin
                            we         = 1'b1;
                            waddr      = r_occ[AW-1:0];
                            wdata.key  = r_cmd.entry_key;
                            wdata.size = r_cmd.entry_size;
                            n_occ      = r_occ + CW'(1);
                            n_out      = mk_out(ST_DONE, '0, 1'b1);
                        end
                        ACT_REMOVE: begin
                            n_out = mk_out(ST_NOFIT, '0, 1'b1);
                        end
                        ACT_SHOW, ACT_LIST: begin
                            if (r_pend_v) begin
                                n_out = mk_out(ST_LISTED, r_pend, 1'b1);
                            end else begin
                                n_out = mk_out(ST_EMPTY, '0, 1'b1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SHIFT: begin
                if (rd_more) begin
                    n_rd_idx = r_rd_idx + CW'(1);
                    n_dv     = 1'b1;
                    n_dv_idx = r_rd_idx[AW-1:0];
                end
                if (r_dv) begin
                    we = 1'b1;
                end
                if (sweep_done) begin
                    n_occ    = r_occ - CW'(1);
                    n_strobe = 1'b1;
                    n_out    = mk_out(ST_DONE, '0, 1'b1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_occ    <= '0;
            r_dv     <= 1'b0;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_dv     <= n_dv;
            r_pend_v <= n_pend_v;
            r_strobe <= n_strobe;
        end
        r_cmd    <= n_cmd;
        r_rd_idx <= n_rd_idx;
        r_dv_idx <= n_dv_idx;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

`ifndef ASSERT_OFF
    a_end_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_strobe)
        else $error("command ended without a final result");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_mid_listed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> (o_result.status == ST_LISTED))
        else $error("non-final result that is not a listed entry");

    a_full_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.action == ACT_INSERT && full)
        |=> (o_strobe && o_result.status == ST_FULL && !busy))
        else $error("insert into full queue not refused at once");
`endif

endmodule
